// ===== design/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int SLOT_LIMIT = 16;
    localparam int CAPACITY = (MAX_PROCS < SLOT_LIMIT) ? MAX_PROCS : SLOT_LIMIT;

    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int ARR_W = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W = 8;
    localparam int WAIT_W = 20;
    localparam int TIME_W = 21;
    localparam int TAT_W = 21;
    localparam int WSUM_W = 24;
    localparam int TSUM_W = 25;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_rd;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_last;
        logic emit_last;
    } t_dp_sts;

endpackage

// ===== design/nps_ctrl.sv =====
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer: load, scan the job table once per pick, then issue one result.
// ----------------------------------------------------------------------------
module nps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last_job,
    input  nps_pkg::t_dp_sts i_sts,
    output nps_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import nps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_job) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last table read is compared in this cycle.
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/nps_datapath.sv =====
// ----------------------------------------------------------------------------
// nps_datapath
// Job table, candidate search registers, clock and running sums.
// ----------------------------------------------------------------------------
module nps_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nps_pkg::t_dp_cmd         i_cmd,
    input  logic [nps_pkg::ARR_W-1:0]   i_arrival_time,
    input  logic [nps_pkg::BURST_W-1:0] i_burst_time,
    input  logic [nps_pkg::PRIO_W-1:0]  i_priority_value,
    output nps_pkg::t_dp_sts         o_sts,
    output logic                     o_result_valid,
    output logic [nps_pkg::IDX_W-1:0]   o_job_index,
    output logic [nps_pkg::WAIT_W-1:0]  o_wait_time,
    output logic [nps_pkg::TIME_W-1:0]  o_completion_time,
    output logic [nps_pkg::TAT_W-1:0]   o_turnaround_time,
    output logic [nps_pkg::WSUM_W-1:0]  o_total_wait,
    output logic [nps_pkg::TSUM_W-1:0]  o_total_turnaround,
    output logic                     o_last_result
);
    import nps_pkg::*;

    // Job table, one entry per load slot.
    logic [ARR_W-1:0]   r_arr_mem   [CAPACITY];
    logic [BURST_W-1:0] r_burst_mem [CAPACITY];
    logic [PRIO_W-1:0]  r_prio_mem  [CAPACITY];

    logic [CAPACITY-1:0] r_fin;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_pick_cnt;
    logic [TIME_W-1:0]   r_time;
    logic [WSUM_W-1:0]   r_wsum;
    logic [TSUM_W-1:0]   r_tsum;
    logic [IDX_W-1:0]    r_scan_idx;

    // Registered table read.
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [ARR_W-1:0]   r_rd_arr;
    logic [BURST_W-1:0] r_rd_burst;
    logic [PRIO_W-1:0]  r_rd_prio;

    // Best job that has already arrived.
    logic               r_ba_vld;
    logic [IDX_W-1:0]   r_ba_idx;
    logic [ARR_W-1:0]   r_ba_arr;
    logic [BURST_W-1:0] r_ba_burst;
    logic [PRIO_W-1:0]  r_ba_prio;

    // Earliest pending job, ties to smaller priority value then lower index.
    logic               r_be_vld;
    logic [IDX_W-1:0]   r_be_idx;
    logic [ARR_W-1:0]   r_be_arr;
    logic [BURST_W-1:0] r_be_burst;
    logic [PRIO_W-1:0]  r_be_prio;

    logic               c_cand;
    logic               c_arrived;
    logic               c_beats_ba;
    logic               c_beats_be;
    logic [IDX_W-1:0]   c_idx;
    logic [ARR_W-1:0]   c_arr;
    logic [BURST_W-1:0] c_burst;
    logic [TIME_W-1:0]  c_start;
    logic [WAIT_W-1:0]  c_wait;
    logic [TIME_W-1:0]  c_done;
    logic [TAT_W-1:0]   c_tat;
    logic [WSUM_W-1:0]  c_wsum;
    logic [TSUM_W-1:0]  c_tsum;
    logic               c_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CNT_W'(CAPACITY))) begin
            r_arr_mem[r_count[IDX_W-1:0]]   <= i_arrival_time;
            r_burst_mem[r_count[IDX_W-1:0]] <= i_burst_time;
            r_prio_mem[r_count[IDX_W-1:0]]  <= i_priority_value;
        end
        if (i_cmd.scan_rd) begin
            r_rd_arr   <= r_arr_mem[r_scan_idx];
            r_rd_burst <= r_burst_mem[r_scan_idx];
            r_rd_prio  <= r_prio_mem[r_scan_idx];
            r_rd_idx   <= r_scan_idx;
        end
    end

    // Compare the job read last cycle against both running candidates.
    always_comb begin
        c_cand    = r_rd_vld && !r_fin[r_rd_idx];
        c_arrived = ({{(TIME_W-ARR_W){1'b0}}, r_rd_arr} <= r_time);
        c_beats_ba = !r_ba_vld || (r_rd_prio < r_ba_prio) ||
                     ((r_rd_prio == r_ba_prio) && (r_rd_arr < r_ba_arr));
        c_beats_be = !r_be_vld || (r_rd_arr < r_be_arr) ||
                     ((r_rd_arr == r_be_arr) && (r_rd_prio < r_be_prio));
    end

    // Dispatch arithmetic for the chosen job.
    always_comb begin
        c_idx   = r_ba_vld ? r_ba_idx : r_be_idx;
        c_arr   = r_ba_vld ? r_ba_arr : r_be_arr;
        c_burst = r_ba_vld ? r_ba_burst : r_be_burst;
        c_start = r_ba_vld ? r_time : {{(TIME_W-ARR_W){1'b0}}, r_be_arr};
        c_wait  = WAIT_W'(c_start - {{(TIME_W-ARR_W){1'b0}}, c_arr});
        c_done  = TIME_W'(c_start + {{(TIME_W-BURST_W){1'b0}}, c_burst});
        c_tat   = TAT_W'({{(TAT_W-WAIT_W){1'b0}}, c_wait} +
                         {{(TAT_W-BURST_W){1'b0}}, c_burst});
        c_wsum  = WSUM_W'(r_wsum + {{(WSUM_W-WAIT_W){1'b0}}, c_wait});
        c_tsum  = TSUM_W'(r_tsum + {{(TSUM_W-TAT_W){1'b0}}, c_tat});
        c_last  = (CNT_W'(r_pick_cnt + 1'b1) == r_count);
    end

    assign o_sts.scan_last = (r_scan_idx == IDX_W'(r_count - 1'b1));
    assign o_sts.emit_last = c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin          <= '0;
            r_count        <= '0;
            r_pick_cnt     <= '0;
            r_time         <= '0;
            r_wsum         <= '0;
            r_tsum         <= '0;
            r_scan_idx     <= '0;
            r_rd_vld       <= 1'b0;
            r_ba_vld       <= 1'b0;
            r_be_vld       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_rd_vld       <= i_cmd.scan_rd;
            o_result_valid <= i_cmd.emit;

            if (i_cmd.load && (r_count < CNT_W'(CAPACITY))) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end

            if (i_cmd.scan_clr) begin
                r_scan_idx <= '0;
                r_ba_vld   <= 1'b0;
                r_be_vld   <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= IDX_W'(r_scan_idx + 1'b1);
                end
                if (c_cand && c_arrived && c_beats_ba) begin
                    r_ba_vld <= 1'b1;
                end
                if (c_cand && c_beats_be) begin
                    r_be_vld <= 1'b1;
                end
            end

            if (i_cmd.emit) begin
                if (c_last) begin
                    r_fin      <= '0;
                    r_count    <= '0;
                    r_pick_cnt <= '0;
                    r_time     <= '0;
                    r_wsum     <= '0;
                    r_tsum     <= '0;
                end else begin
                    r_fin[c_idx] <= 1'b1;
                    r_pick_cnt   <= CNT_W'(r_pick_cnt + 1'b1);
                    r_time       <= c_done;
                    r_wsum       <= c_wsum;
                    r_tsum       <= c_tsum;
                end
            end
        end
    end

    // Candidate payloads.
    always_ff @(posedge i_clk) begin
        if (c_cand && c_arrived && c_beats_ba) begin
            r_ba_idx   <= r_rd_idx;
            r_ba_arr   <= r_rd_arr;
            r_ba_burst <= r_rd_burst;
            r_ba_prio  <= r_rd_prio;
        end
        if (c_cand && c_beats_be) begin
            r_be_idx   <= r_rd_idx;
            r_be_arr   <= r_rd_arr;
            r_be_burst <= r_rd_burst;
            r_be_prio  <= r_rd_prio;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_job_index        <= c_idx;
            o_wait_time        <= c_wait;
            o_completion_time  <= c_done;
            o_turnaround_time  <= c_tat;
            o_total_wait       <= c_last ? c_wsum : '0;
            o_total_turnaround <= c_last ? c_tsum : '0;
            o_last_result      <= c_last;
        end
    end

    // Every pick must have found at least one unfinished job.
    a_emit_has_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_ba_vld || r_be_vld))
        else $error("dispatch with no candidate job");

    // The table never holds more jobs than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("job count above capacity");

    // A dispatched job was not finished before.
    a_pick_unfinished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_fin[c_idx])
        else $error("finished job dispatched again");

    // Picks in a set never reach the job count.
    a_pick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_pick_cnt < r_count))
        else $error("more picks than jobs");

endmodule

// ===== design/nonpreemptive_priority_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// Loads a set of jobs and dispatches them by priority without preemption.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  --------  ---------------------  --------------------------------------------
//  job in    start & !busy          arrival, burst, priority, last_job mark
//  result    o_result_valid strobe  index, wait, completion, turnaround, totals
//
//  The beat marked last_job starts dispatch, and each pick then scans the
//  job table once through its single read port, reading every loaded job.
//  busy rises after the last_job beat and is low again in the cycle that
//  shows the final result. Each result is held for one cycle only; the
//  receiver cannot stall it. Reset is synchronous and active low; it empties
//  the table and the clock.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [nps_pkg::ARR_W-1:0]       i_arrival_time,
    input  logic [nps_pkg::BURST_W-1:0]     i_burst_time,
    input  logic [nps_pkg::PRIO_W-1:0]      i_priority_value,
    input  logic                            i_last_job,
    output logic                            o_result_valid,
    output logic [nps_pkg::IDX_W-1:0]       o_job_index,
    output logic [nps_pkg::WAIT_W-1:0]      o_wait_time,
    output logic [nps_pkg::TIME_W-1:0]      o_completion_time,
    output logic [nps_pkg::TAT_W-1:0]       o_turnaround_time,
    output logic [nps_pkg::WSUM_W-1:0]      o_total_wait,
    output logic [nps_pkg::TSUM_W-1:0]      o_total_turnaround,
    output logic                            o_last_result
);
    import nps_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller walks idle, scan, drain and emit; the datapath holds the
    // table, the two running candidates (best arrived job and earliest
    // pending job) and the set's clock and sums. When no job has arrived the
    // earliest pending one is taken and the clock jumps to its arrival.
    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_job (i_last_job),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    nps_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_priority_value   (i_priority_value),
        .o_sts              (w_sts),
        .o_result_valid     (o_result_valid),
        .o_job_index        (o_job_index),
        .o_wait_time        (o_wait_time),
        .o_completion_time  (o_completion_time),
        .o_turnaround_time  (o_turnaround_time),
        .o_total_wait       (o_total_wait),
        .o_total_turnaround (o_total_turnaround),
        .o_last_result      (o_last_result)
    );

endmodule

// ===== verif/tb_nonpreemptive_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler_core
// Loads job sets into the scheduler core and checks every dispatch result.
// Each accepted job beat updates a model of the job table. The beat marked
// last_job runs a software dispatch of the whole set, and its results are
// queued in dispatch order. Every result strobe is compared, field by field,
// with the oldest queued dispatch.
// ----------------------------------------------------------------------------

// One dispatched job, at the widths of the result ports.
typedef struct {
    logic [nps_pkg::IDX_W-1:0]  job_index;
    logic [nps_pkg::WAIT_W-1:0] wait_time;
    logic [nps_pkg::TIME_W-1:0] completion_time;
    logic [nps_pkg::TAT_W-1:0]  turnaround_time;
    logic [nps_pkg::WSUM_W-1:0] total_wait;
    logic [nps_pkg::TSUM_W-1:0] total_turnaround;
    logic                       last_result;
} t_dispatch;

class dispatch_scoreboard;

    logic [nps_pkg::ARR_W-1:0]   arrival_tab[nps_pkg::SLOT_LIMIT];
    logic [nps_pkg::BURST_W-1:0] burst_tab[nps_pkg::SLOT_LIMIT];
    logic [nps_pkg::PRIO_W-1:0]  prio_tab[nps_pkg::SLOT_LIMIT];
    bit                          done_tab[nps_pkg::SLOT_LIMIT];
    int unsigned                 loaded;
    logic [nps_pkg::TIME_W-1:0]  clock_now;
    logic [nps_pkg::WSUM_W-1:0]  wait_total;
    logic [nps_pkg::TSUM_W-1:0]  tat_total;
    t_dispatch                   dispatch_q[$];
    int unsigned                 errors;

    function new();
        errors = 0;
        clear_set();
    endfunction

    function void clear_set();
        foreach (done_tab[i]) done_tab[i] = 1'b0;
        loaded = 0;
        clock_now = '0;
        wait_total = '0;
        tat_total = '0;
    endfunction

    function int unsigned pending();
        return dispatch_q.size();
    endfunction

    // Order of precedence: lower priority value, then earlier arrival,
    // then lower load index.
    function bit wins(int unsigned a, int unsigned b);
        if (prio_tab[a] != prio_tab[b]) return prio_tab[a] < prio_tab[b];
        if (arrival_tab[a] != arrival_tab[b]) return arrival_tab[a] < arrival_tab[b];
        return a < b;
    endfunction

    // Runs the whole set to completion and queues one dispatch per job.
    function void dispatch_set();
        int unsigned k;
        int unsigned i;
        int unsigned best;
        int unsigned earliest;
        int unsigned wait_v;
        int unsigned finish_v;
        int unsigned tat_v;
        int unsigned sum_v;
        bit          found;
        t_dispatch   d;
        for (k = 0; k < loaded; k++) begin
            // Skip the clock over an idle stretch before picking.
            earliest = 32'hFFFF_FFFF;
            for (i = 0; i < loaded; i++)
                if (!done_tab[i] && arrival_tab[i] < earliest) earliest = arrival_tab[i];
            if (earliest != 32'hFFFF_FFFF && earliest > clock_now)
                clock_now = earliest[nps_pkg::TIME_W-1:0];
            found = 1'b0;
            best = 0;
            for (i = 0; i < loaded; i++) begin
                if (!done_tab[i] && arrival_tab[i] <= clock_now) begin
                    if (!found || wins(i, best)) begin
                        best = i;
                        found = 1'b1;
                    end
                end
            end
            wait_v = clock_now - arrival_tab[best];
            finish_v = clock_now + burst_tab[best];
            tat_v = wait_v + burst_tab[best];
            done_tab[best] = 1'b1;
            clock_now = finish_v[nps_pkg::TIME_W-1:0];
            sum_v = wait_total + wait_v;
            wait_total = sum_v[nps_pkg::WSUM_W-1:0];
            sum_v = tat_total + tat_v;
            tat_total = sum_v[nps_pkg::TSUM_W-1:0];
            d.job_index = best[nps_pkg::IDX_W-1:0];
            d.wait_time = wait_v[nps_pkg::WAIT_W-1:0];
            d.completion_time = finish_v[nps_pkg::TIME_W-1:0];
            d.turnaround_time = tat_v[nps_pkg::TAT_W-1:0];
            d.last_result = (k + 1 == loaded);
            d.total_wait = d.last_result ? wait_total : '0;
            d.total_turnaround = d.last_result ? tat_total : '0;
            dispatch_q.push_back(d);
        end
        clear_set();
    endfunction

    // Called for every accepted job beat.
    function void note_job(logic [nps_pkg::ARR_W-1:0] arrival,
                           logic [nps_pkg::BURST_W-1:0] burst,
                           logic [nps_pkg::PRIO_W-1:0] prio, logic last_job);
        if (loaded < nps_pkg::CAPACITY) begin
            arrival_tab[loaded] = arrival;
            burst_tab[loaded] = burst;
            prio_tab[loaded] = prio;
            done_tab[loaded] = 1'b0;
            loaded++;
        end
        if (last_job) dispatch_set();
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // Called for every result strobe.
    function void check_result(t_dispatch got);
        t_dispatch want;
        if (dispatch_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual job_index %0d",
                     $time, got.job_index);
            return;
        end
        want = dispatch_q.pop_front();
        compare("job_index", want.job_index, got.job_index);
        compare("wait_time", want.wait_time, got.wait_time);
        compare("completion_time", want.completion_time, got.completion_time);
        compare("turnaround_time", want.turnaround_time, got.turnaround_time);
        compare("total_wait", want.total_wait, got.total_wait);
        compare("total_turnaround", want.total_turnaround, got.total_turnaround);
        compare("last_result", want.last_result, got.last_result);
    endfunction

endclass

module tb_nonpreemptive_priority_scheduler_core;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [nps_pkg::ARR_W-1:0]       i_arrival_time = '0;
    logic [nps_pkg::BURST_W-1:0]     i_burst_time = '0;
    logic [nps_pkg::PRIO_W-1:0]      i_priority_value = '0;
    logic                            i_last_job = 1'b0;
    logic                            o_result_valid;
    logic [nps_pkg::IDX_W-1:0]       o_job_index;
    logic [nps_pkg::WAIT_W-1:0]      o_wait_time;
    logic [nps_pkg::TIME_W-1:0]      o_completion_time;
    logic [nps_pkg::TAT_W-1:0]       o_turnaround_time;
    logic [nps_pkg::WSUM_W-1:0]      o_total_wait;
    logic [nps_pkg::TSUM_W-1:0]      o_total_turnaround;
    logic                            o_last_result;

    dispatch_scoreboard sb;

    // Sender pacing: a burst of back-to-back beats, then a gap that may be empty.
    int unsigned burst_left = 0;
    // Number of jobs that landed in the table, overflow beats excluded.
    int unsigned jobs_stored = 0;

    nonpreemptive_priority_scheduler_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_priority_value   (i_priority_value),
        .i_last_job         (i_last_job),
        .o_result_valid     (o_result_valid),
        .o_job_index        (o_job_index),
        .o_wait_time        (o_wait_time),
        .o_completion_time  (o_completion_time),
        .o_turnaround_time  (o_turnaround_time),
        .o_total_wait       (o_total_wait),
        .o_total_turnaround (o_total_turnaround),
        .o_last_result      (o_last_result)
    );

    always #10 i_clk = ~i_clk;

    // Monitor. Inputs are driven by nonblocking assignments at the rising edge,
    // so the values read here are the ones the block saw at this same edge.
    // A job beat moves when start is high and busy is low; a result beat moves
    // whenever the strobe is high, since the result lasts one cycle only.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_job(i_arrival_time, i_burst_time, i_priority_value, i_last_job);
            if (o_result_valid)
                sb.check_result('{job_index: o_job_index, wait_time: o_wait_time,
                                  completion_time: o_completion_time,
                                  turnaround_time: o_turnaround_time,
                                  total_wait: o_total_wait,
                                  total_turnaround: o_total_turnaround,
                                  last_result: o_last_result});
        end
    end

    // Presents one job beat and returns at the edge that accepts it. The
    // caller is always at a rising edge, so start stays high between beats
    // of a burst without being lowered in between.
    task automatic send_job(input logic [nps_pkg::ARR_W-1:0] arrival,
                            input logic [nps_pkg::BURST_W-1:0] burst,
                            input logic [nps_pkg::PRIO_W-1:0] prio,
                            input logic last_job);
        start <= 1'b1;
        i_arrival_time <= arrival;
        i_burst_time <= burst;
        i_priority_value <= prio;
        i_last_job <= last_job;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Same as send_job, but may open a random gap whenever a burst runs out.
    // While the gap lasts the data ports carry junk, which must be ignored.
    task automatic paced_job(input logic [nps_pkg::ARR_W-1:0] arrival,
                             input logic [nps_pkg::BURST_W-1:0] burst,
                             input logic [nps_pkg::PRIO_W-1:0] prio,
                             input logic last_job);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap != 0) begin
                start <= 1'b0;
                i_arrival_time <= 16'($urandom);
                i_burst_time <= 16'($urandom);
                i_priority_value <= 8'($urandom);
                i_last_job <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_job(arrival, burst, prio, last_job);
    endtask

    // Holds off new beats until every queued dispatch has come out. The
    // queue is looked at on falling edges, clear of the monitor's updates.
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    // Sends a well-formed set of n beats with the mark on the final one.
    // Sets larger than the table are legal: the surplus beats are dropped,
    // but the mark on the final beat still starts dispatch.
    //   style 0: values over the whole range of every field
    //   style 1: crowded values, so that priority and arrival ties abound
    //   style 2: spread arrivals with short bursts, so the clock often idles
    task automatic send_set(input int unsigned n, input int unsigned style);
        int unsigned j;
        logic [nps_pkg::ARR_W-1:0]   arrival;
        logic [nps_pkg::BURST_W-1:0] burst;
        logic [nps_pkg::PRIO_W-1:0]  prio;
        for (j = 0; j < n; j++) begin
            case (style)
                1: begin
                    arrival = 16'($urandom_range(0, 20));
                    burst = 16'($urandom_range(0, 8));
                    prio = 8'($urandom_range(0, 3));
                end
                2: begin
                    arrival = 16'($urandom);
                    burst = 16'($urandom_range(0, 300));
                    prio = 8'($urandom);
                end
                default: begin
                    arrival = 16'($urandom);
                    burst = 16'($urandom);
                    prio = 8'($urandom);
                end
            endcase
            paced_job(arrival, burst, prio, j == n - 1);
        end
        jobs_stored += (n < nps_pkg::CAPACITY) ? n : nps_pkg::CAPACITY;
    endtask

    initial begin
        int unsigned i;
        int unsigned n;
        int unsigned sets_sent;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A lone job with every field at zero, then a lone job
        // with every field at its top value, which also forces an idle jump.
        send_job(16'h0000, 16'h0000, 8'h00, 1'b1);
        send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);

        // Only job 2 has arrived at time zero. Once it ends, jobs 0, 1 and 3
        // tie on priority: the earlier arrival (job 3) goes first, then the
        // exact tie of jobs 0 and 1 falls to the lower load index.
        send_job(16'd5, 16'd10, 8'd3, 1'b0);
        send_job(16'd5, 16'd4, 8'd3, 1'b0);
        send_job(16'd0, 16'd7, 8'd9, 1'b0);
        send_job(16'd2, 16'd1, 8'd3, 1'b1);

        // The clock runs dry in the middle of the set and jumps ahead.
        send_job(16'd0, 16'd1, 8'd5, 1'b0);
        send_job(16'd100, 16'd2, 8'd0, 1'b1);

        // A full table, plus one extra beat whose data must be dropped while
        // its mark still starts dispatch. Field extremes are mixed in.
        for (i = 0; i < nps_pkg::CAPACITY; i++)
            send_job((i == 0) ? 16'hFFFF : 16'(i * 7), (i == 15) ? 16'hFFFF : 16'(i),
                     (i % 2) ? 8'hFF : 8'h00, 1'b0);
        send_job(16'h0000, 16'h0000, 8'h00, 1'b1);

        // Hold everything back until the directed sets have fully drained.
        wait_drained();

        // Random part: mostly small sets, some full ones, some oversized.
        sets_sent = 0;
        while (jobs_stored < 450) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n = $urandom_range(1, 6);
                6, 7: n = $urandom_range(7, 16);
                8: n = nps_pkg::CAPACITY;
                default: n = $urandom_range(nps_pkg::CAPACITY + 1, nps_pkg::CAPACITY + 3);
            endcase
            send_set(n, $urandom_range(0, 2));
            sets_sent++;
            if (sets_sent % 8 == 0) wait_drained();
        end

        // Let every dispatch come out, then give the block time to show any
        // stray result beyond the last one expected.
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/nps_pkg.sv
design/nps_ctrl.sv
design/nps_datapath.sv
design/nonpreemptive_priority_scheduler_core.sv
verif/tb_nonpreemptive_priority_scheduler_core.sv
